[sv/hc2_pkg.sv]
// Shared types, constants and mod-26 helpers for the 2x2 Hill cipher block.
package hc2_pkg;

   localparam int unsigned LETTER_W   = 5;
   localparam int unsigned PROD_W     = 10;
   localparam int unsigned SUM_W      = 11;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 5;
   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW    = FIFO_AW + 1;

   localparam logic [LETTER_W-1:0] MODULUS    = 5'd26;
   localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;
   localparam logic [SUM_W-1:0]    DET_BIAS   = 11'd676;

   localparam logic [LETTER_W-1:0] KEY_TL_RST = 5'd3;
   localparam logic [LETTER_W-1:0] KEY_TR_RST = 5'd3;
   localparam logic [LETTER_W-1:0] KEY_BL_RST = 5'd2;
   localparam logic [LETTER_W-1:0] KEY_BR_RST = 5'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_TOP_LEFT     = 3'd0,
      CSR_KEY_TOP_RIGHT    = 3'd1,
      CSR_KEY_BOTTOM_LEFT  = 3'd2,
      CSR_KEY_BOTTOM_RIGHT = 3'd3,
      CSR_DECRYPT_MODE     = 3'd4
   } hc2_csr_type;

   typedef enum logic {
      KIND_PAIR  = 1'b0,
      KIND_ERROR = 1'b1
   } hc2_kind_type;

   typedef struct packed {
      logic [LETTER_W-1:0] letter_in;
      logic                last_in;
   } hc2_req_type;

   typedef struct packed {
      logic [LETTER_W-1:0] letter_out;
      logic                last_out;
      logic                key_error;
   } hc2_rsp_type;

   // 5-bit value to 0..25: one compare and subtract.
   function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] v);
      logic [LETTER_W-1:0] r;
      r = (v >= MODULUS) ? v - MODULUS : v;
      return r;
   endfunction

   // Additive inverse of a reduced value.
   function automatic logic [LETTER_W-1:0] neg26(input logic [LETTER_W-1:0] v);
      logic [LETTER_W-1:0] r;
      r = (v == '0) ? '0 : MODULUS - v;
      return r;
   endfunction

   // Values below 1302 to 0..25: quotient estimate by 78/2048 never overshoots
   // and is at most one low, so one compare and subtract finishes it.
   function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] s);
      logic [17:0]      scaled;
      logic [5:0]       q;
      logic [SUM_W-1:0] qm;
      logic [5:0]       r;
      logic [5:0]       rr;
      scaled = 18'(s) * 18'd78;
      q      = scaled[17:11] > 7'd63 ? 6'd63 : scaled[16:11];
      qm     = (SUM_W'(q) << 4) + (SUM_W'(q) << 3) + (SUM_W'(q) << 1);
      r      = 6'(s - qm);
      rr     = (r >= 6'd26) ? r - 6'd26 : r;
      return rr[LETTER_W-1:0];
   endfunction

   // Multiplicative inverse mod 26; 0 where none exists.
   function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] v);
      logic [LETTER_W-1:0] r;
      case (v)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

[sv/hill_cipher_2x2.sv]
// Hill cipher on letter pairs with a 2x2 key mod 26, top level.
//
// Letters (0..25) enter one per cycle on the req channel while req_stall is
// low and are paired; each completed pair yields two result beats on the rsp
// channel, a lone final letter is padded with X. A pair's products are
// registered and then written into the result queue; results leave it at
// one beat per cycle while rsp_stall is low. Decrypt mode multiplies by the
// inverse key; if the key has no inverse, letters are swallowed and the final
// letter gives one beat with key_error set. The effective matrix is built from
// the key registers in a three-stage pipeline (products, determinant inverse,
// adjugate scaling), so req_stall is held high after reset and after every csr
// write until the new matrix has reached the last stage. req_stall also rises
// when the eight-beat result queue cannot take another pair.
module hill_cipher_2x2 (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  hc2_pkg::hc2_req_type                     req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output hc2_pkg::hc2_rsp_type                     rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [hc2_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [hc2_pkg::CSR_DATA_W-1:0]           csr_data
);
   import hc2_pkg::*;

   // configuration registers
   logic [LETTER_W-1:0] key_tl_ff, key_tr_ff, key_bl_ff, key_br_ff;
   logic                dec_ff;
   logic [1:0]          settle_ff, settle_in;
   logic                csr_wr;

   // matrix pipeline
   logic [LETTER_W-1:0] ka_in, kb_in, kc_in, kd_in;
   logic [LETTER_W-1:0] ka1_ff, kb1_ff, kc1_ff, kd1_ff;
   logic [PROD_W-1:0]   ad_ff, bc_ff;
   logic                dec1_ff;
   logic [LETTER_W-1:0] ka2_ff, kb2_ff, kc2_ff, kd2_ff, di_ff, di_in;
   logic                dec2_ff;
   logic [LETTER_W-1:0] m00_ff, m01_ff, m10_ff, m11_ff;
   logic [LETTER_W-1:0] m00_in, m01_in, m10_in, m11_in;
   logic                bad_ff, bad_in;

   // pairing state and item path
   logic                accept;
   logic [LETTER_W-1:0] letter;
   logic                holding_ff, holding_in;
   logic [LETTER_W-1:0] held_ff, held_in;
   logic [LETTER_W-1:0] p0, p1;
   logic                s1_valid_ff, s1_valid_in;
   hc2_kind_type        s1_kind_ff, s1_kind_in;
   logic                s1_last_ff;
   logic [PROD_W-1:0]   pr00_ff, pr01_ff, pr10_ff, pr11_ff;

   // result queue
   hc2_rsp_type         fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]  count_ff, count_in;
   logic [1:0]          push_n;
   logic                pop;
   hc2_rsp_type         push0, push1;
   logic [FIFO_CW:0]    demand;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_tl_ff <= KEY_TL_RST;
         key_tr_ff <= KEY_TR_RST;
         key_bl_ff <= KEY_BL_RST;
         key_br_ff <= KEY_BR_RST;
         dec_ff    <= 1'b0;
         settle_ff <= 2'd3;
      end else begin
         settle_ff <= settle_in;
         if (csr_wr) begin
            case (hc2_csr_type'(csr_index))
               CSR_KEY_TOP_LEFT:     key_tl_ff <= csr_data[LETTER_W-1:0];
               CSR_KEY_TOP_RIGHT:    key_tr_ff <= csr_data[LETTER_W-1:0];
               CSR_KEY_BOTTOM_LEFT:  key_bl_ff <= csr_data[LETTER_W-1:0];
               CSR_KEY_BOTTOM_RIGHT: key_br_ff <= csr_data[LETTER_W-1:0];
               CSR_DECRYPT_MODE:     dec_ff    <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // hold off items until the matrix pipeline has the new key
   always_comb begin
      if (csr_wr)
         settle_in = 2'd3;
      else if (settle_ff != 2'd0)
         settle_in = settle_ff - 2'd1;
      else
         settle_in = settle_ff;
   end

   // ---------------- matrix pipeline ----------------
   assign ka_in = red26(key_tl_ff);
   assign kb_in = red26(key_tr_ff);
   assign kc_in = red26(key_bl_ff);
   assign kd_in = red26(key_br_ff);

   assign di_in = inv26(mod26(SUM_W'(ad_ff) + DET_BIAS - SUM_W'(bc_ff)));

   always_comb begin
      if (dec2_ff) begin
         m00_in = mod26(SUM_W'(PROD_W'(di_ff) * PROD_W'(kd2_ff)));
         m01_in = mod26(SUM_W'(PROD_W'(di_ff) * PROD_W'(neg26(kb2_ff))));
         m10_in = mod26(SUM_W'(PROD_W'(di_ff) * PROD_W'(neg26(kc2_ff))));
         m11_in = mod26(SUM_W'(PROD_W'(di_ff) * PROD_W'(ka2_ff)));
         bad_in = (di_ff == '0);
      end else begin
         m00_in = ka2_ff;
         m01_in = kb2_ff;
         m10_in = kc2_ff;
         m11_in = kd2_ff;
         bad_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ka1_ff  <= ka_in;
      kb1_ff  <= kb_in;
      kc1_ff  <= kc_in;
      kd1_ff  <= kd_in;
      ad_ff   <= PROD_W'(ka_in) * PROD_W'(kd_in);
      bc_ff   <= PROD_W'(kb_in) * PROD_W'(kc_in);
      dec1_ff <= dec_ff;
      ka2_ff  <= ka1_ff;
      kb2_ff  <= kb1_ff;
      kc2_ff  <= kc1_ff;
      kd2_ff  <= kd1_ff;
      di_ff   <= di_in;
      dec2_ff <= dec1_ff;
      m00_ff  <= m00_in;
      m01_ff  <= m01_in;
      m10_ff  <= m10_in;
      m11_ff  <= m11_in;
      bad_ff  <= bad_in;
   end

   // ---------------- pairing and products ----------------
   assign accept = req_valid & ~req_stall;
   assign letter = red26(req_data.letter_in);

   always_comb begin
      holding_in  = holding_ff;
      held_in     = held_ff;
      s1_valid_in = 1'b0;
      s1_kind_in  = KIND_PAIR;
      p0          = held_ff;
      p1          = letter;
      if (accept) begin
         if (bad_ff) begin
            if (req_data.last_in) begin
               holding_in  = 1'b0;
               held_in     = '0;
               s1_valid_in = 1'b1;
               s1_kind_in  = KIND_ERROR;
            end else if (holding_ff) begin
               holding_in = 1'b0;
            end else begin
               holding_in = 1'b1;
               held_in    = letter;
            end
         end else if (holding_ff) begin
            holding_in  = 1'b0;
            held_in     = '0;
            s1_valid_in = 1'b1;
         end else if (req_data.last_in) begin
            // pad a lone final letter
            p0          = letter;
            p1          = PAD_LETTER;
            held_in     = '0;
            s1_valid_in = 1'b1;
         end else begin
            holding_in = 1'b1;
            held_in    = letter;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holding_ff  <= 1'b0;
         held_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         holding_ff  <= holding_in;
         held_ff     <= held_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= s1_kind_in;
      s1_last_ff <= req_data.last_in;
      pr00_ff    <= PROD_W'(m00_ff) * PROD_W'(p0);
      pr01_ff    <= PROD_W'(m01_ff) * PROD_W'(p1);
      pr10_ff    <= PROD_W'(m10_ff) * PROD_W'(p0);
      pr11_ff    <= PROD_W'(m11_ff) * PROD_W'(p1);
   end

   // ---------------- result queue ----------------
   always_comb begin
      push0  = '0;
      push1  = '0;
      push_n = 2'd0;
      if (s1_valid_ff) begin
         case (s1_kind_ff)
            KIND_ERROR: begin
               push0.last_out  = 1'b1;
               push0.key_error = 1'b1;
               push_n          = 2'd1;
            end
            KIND_PAIR: begin
               push0.letter_out = mod26(SUM_W'(pr00_ff) + SUM_W'(pr01_ff));
               push1.letter_out = mod26(SUM_W'(pr10_ff) + SUM_W'(pr11_ff));
               push1.last_out   = s1_last_ff;
               push_n           = 2'd2;
            end
            default: push_n = 2'd0;
         endcase
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];
   assign pop       = rsp_valid & ~rsp_stall;

   assign wr_ptr_in = wr_ptr_ff + FIFO_AW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
   assign count_in  = count_ff + FIFO_CW'(push_n) - FIFO_CW'(pop);

   // reserve room for the beats in flight plus a full pair
   assign demand    = (FIFO_CW+1)'(count_ff) + ((FIFO_CW+1)'(s1_valid_ff) << 1)
                      + (FIFO_CW+1)'(2);
   assign req_stall = (settle_ff != 2'd0) || (demand > (FIFO_CW+1)'(FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0)
         fifo_ff[wr_ptr_ff] <= push0;
      if (push_n == 2'd2)
         fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= push1;
   end

   // ---------------- checks ----------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_stage_from_accept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(accept))
      else $error("product stage loaded without an accepted beat");

   a_last_clears_pair: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_in |=> !holding_ff && s1_valid_ff)
      else $error("final letter left a pair open or gave no result");

   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.key_error |-> rsp_data.last_out && rsp_data.letter_out == '0)
      else $error("key error beat malformed");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.letter_out < MODULUS)
      else $error("result letter out of range");

endmodule
